// ===== sv/dcrtc_pkg.sv =====
// ----------------------------------------------------------------------------
// dcrtc_pkg
// Shared codes and field widths for the day-counting real-time clock.
// ----------------------------------------------------------------------------
package dcrtc_pkg;

  // Default day counter width
  localparam int DayWidthDef = 17;

  // Bus word width of the register file
  localparam int BusWidth = 21;

  // Packed stream word widths (whole bytes)
  localparam int InDataWidth  = 24;
  localparam int OutDataWidth = 24;

  // Time field widths
  localparam int SecWidth  = 6;
  localparam int MinWidth  = 6;
  localparam int HourWidth = 5;

  // Last legal values before a wrap
  localparam logic [SecWidth-1:0]  SecLast  = 6'd59;
  localparam logic [MinWidth-1:0]  MinLast  = 6'd59;
  localparam logic [HourWidth-1:0] HourLast = 5'd23;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_e;

  // Register indexes
  localparam logic [2:0] RegTime      = 3'd0;
  localparam logic [2:0] RegDay       = 3'd1;
  localparam logic [2:0] RegAlarmTime = 3'd2;
  localparam logic [2:0] RegAlarmDay  = 3'd3;
  localparam logic [2:0] RegControl   = 3'd4;
  localparam logic [2:0] RegStatus    = 3'd5;

endpackage

// ===== sv/day_counter_rtc_with_alarm.sv =====
// ----------------------------------------------------------------------------
// day_counter_rtc_with_alarm
// Throughput: one word per cycle while the skid entry is empty; the state
// update and result are one register stage, and a two-entry output (main
// plus skid) keeps input open while a result waits. Reset clears all clock,
// alarm and control state.
// ----------------------------------------------------------------------------
module day_counter_rtc_with_alarm #(
  parameter int DAY_WIDTH = dcrtc_pkg::DayWidthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata: reg_index [2:0], write_data [23:3]
  input  logic [dcrtc_pkg::InDataWidth-1:0]  s_axis_tdata_i,
  // tuser: mode [1:0]
  input  logic [1:0]                         s_axis_tuser_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: read_data [20:0], interrupt [21], zero [23:22]
  output logic [dcrtc_pkg::OutDataWidth-1:0] m_axis_tdata_o,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i
);
  import dcrtc_pkg::*;

  // Day bits visible on the bus
  localparam int RdW = (DAY_WIDTH < BusWidth) ? DAY_WIDTH : BusWidth;

  // Input word fields
  logic [2:0]          reg_index;
  logic [BusWidth-1:0] write_data;
  logic                accept;

  assign reg_index  = s_axis_tdata_i[2:0];
  assign write_data = s_axis_tdata_i[3 +: BusWidth];
  assign accept     = s_axis_tvalid_i && s_axis_tready_o;

  // Clock and alarm state
  logic [SecWidth-1:0]  sec_q, sec_d;
  logic [MinWidth-1:0]  min_q, min_d;
  logic [HourWidth-1:0] hour_q, hour_d;
  logic [DAY_WIDTH-1:0] day_q, day_d;
  logic [SecWidth-1:0]  al_sec_q, al_sec_d;
  logic [MinWidth-1:0]  al_min_q, al_min_d;
  logic [HourWidth-1:0] al_hour_q, al_hour_d;
  logic [DAY_WIDTH-1:0] al_day_q, al_day_d;
  logic                 irq_en_q, irq_en_d;
  logic                 time_en_q, time_en_d;
  logic [3:0]           period_q, period_d;
  logic                 alarm_q, alarm_d;

  logic [BusWidth-1:0]     rd_data;
  logic [OutDataWidth-1:0] res_word;

  // Next state and result for the word at the input
  always_comb begin
    sec_d     = sec_q;
    min_d     = min_q;
    hour_d    = hour_q;
    day_d     = day_q;
    al_sec_d  = al_sec_q;
    al_min_d  = al_min_q;
    al_hour_d = al_hour_q;
    al_day_d  = al_day_q;
    irq_en_d  = irq_en_q;
    time_en_d = time_en_q;
    period_d  = period_q;
    alarm_d   = alarm_q;
    rd_data   = '0;

    unique case (s_axis_tuser_i)
      MODE_TICK: begin
        if (time_en_q) begin
          // Advance with ripple carry; out-of-range fields wrap as if at last value
          if (sec_q >= SecLast) begin
            sec_d = '0;
            if (min_q >= MinLast) begin
              min_d = '0;
              if (hour_q >= HourLast) begin
                hour_d = '0;
                day_d  = day_q + DAY_WIDTH'(1);
              end else begin
                hour_d = hour_q + HourWidth'(1);
              end
            end else begin
              min_d = min_q + MinWidth'(1);
            end
          end else begin
            sec_d = sec_q + SecWidth'(1);
          end
          // Compare the new time against the alarm
          if (sec_d == al_sec_q && min_d == al_min_q && hour_d == al_hour_q &&
              day_d == al_day_q) begin
            alarm_d = 1'b1;
          end
        end
      end
      MODE_READ: begin
        unique case (reg_index)
          RegTime: begin
            rd_data[5:0]   = sec_q;
            rd_data[13:8]  = min_q;
            rd_data[20:16] = hour_q;
          end
          RegDay:      rd_data[RdW-1:0] = day_q[RdW-1:0];
          RegAlarmTime: begin
            rd_data[5:0]   = al_sec_q;
            rd_data[13:8]  = al_min_q;
            rd_data[20:16] = al_hour_q;
          end
          RegAlarmDay: rd_data[RdW-1:0] = al_day_q[RdW-1:0];
          RegControl: begin
            rd_data[0]    = irq_en_q;
            rd_data[4]    = time_en_q;
            rd_data[11:8] = period_q;
          end
          RegStatus:   rd_data[0] = alarm_q;
          default:     rd_data = '0;
        endcase
      end
      MODE_WRITE: begin
        unique case (reg_index)
          RegTime: begin
            sec_d  = write_data[5:0];
            min_d  = write_data[13:8];
            hour_d = write_data[20:16];
          end
          RegDay:      day_d = DAY_WIDTH'(write_data);
          RegAlarmTime: begin
            al_sec_d  = write_data[5:0];
            al_min_d  = write_data[13:8];
            al_hour_d = write_data[20:16];
          end
          RegAlarmDay: al_day_d = DAY_WIDTH'(write_data);
          RegControl: begin
            irq_en_d  = write_data[0];
            time_en_d = write_data[4];
            period_d  = write_data[11:8];
          end
          RegStatus: begin
            // Write one to clear, zero keeps
            if (write_data[0]) begin
              alarm_d = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    res_word = {2'b00, alarm_d & irq_en_d, rd_data};
  end

  // Commit state only on an accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q     <= '0;
      min_q     <= '0;
      hour_q    <= '0;
      day_q     <= '0;
      al_sec_q  <= '0;
      al_min_q  <= '0;
      al_hour_q <= '0;
      al_day_q  <= '0;
      irq_en_q  <= 1'b0;
      time_en_q <= 1'b0;
      period_q  <= '0;
      alarm_q   <= 1'b0;
    end else if (accept) begin
      sec_q     <= sec_d;
      min_q     <= min_d;
      hour_q    <= hour_d;
      day_q     <= day_d;
      al_sec_q  <= al_sec_d;
      al_min_q  <= al_min_d;
      al_hour_q <= al_hour_d;
      al_day_q  <= al_day_d;
      irq_en_q  <= irq_en_d;
      time_en_q <= time_en_d;
      period_q  <= period_d;
      alarm_q   <= alarm_d;
    end
  end

  // Output register with skid stage
  logic                    out_valid_q;
  logic                    skid_valid_q;
  logic [OutDataWidth-1:0] out_data_q;
  logic [OutDataWidth-1:0] skid_data_q;
  logic                    out_free;

  // Take input whenever the skid entry is empty
  assign s_axis_tready_o = !skid_valid_q;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      // Refill the main register, skid first
      out_valid_q  <= skid_valid_q || accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      // Main stalled: park the new result
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : res_word;
    end else if (accept) begin
      skid_data_q <= res_word;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  // Skid never holds a word unless the main register does
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty output register");

  // Disabled tick leaves time untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser_i == MODE_TICK && !time_en_q) |=>
      ($stable(sec_q) && $stable(min_q) && $stable(hour_q) && $stable(day_q)))
    else $error("time advanced while disabled");

  // Alarm sets only on an accepted tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(alarm_q) |-> $past(accept && s_axis_tuser_i == MODE_TICK))
    else $error("alarm set without a tick");

  // Alarm clears only on a write of one to status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(alarm_q) |-> $past(accept && s_axis_tuser_i == MODE_WRITE &&
                             reg_index == RegStatus && write_data[0]))
    else $error("alarm cleared without a status write");
`endif

endmodule
